// ===== src/rgb_frame_difference_mse_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef RGB_FRAME_DIFFERENCE_MSE_MACROS_SVH
`define RGB_FRAME_DIFFERENCE_MSE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RFDM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfdm check failed");

// Next-cycle implication, checked out of reset.
`define RFDM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfdm check failed");

`endif

// ===== src/rfdm_pkg.sv =====
package rfdm_pkg;

	localparam int MAX_FRAME_PIXELS_DEF = 16777216;
	localparam int SUM_W     = 40;
	localparam int TOT_W     = SUM_W + 2;
	localparam int FRAC_W    = 8;
	localparam int DVD_W     = TOT_W + FRAC_W;
	localparam int DVS_W_DEF = 25;
	localparam int PIX_W     = 8;
	localparam int MSE_CH_W  = 24;
	localparam int MSE_TOT_W = 26;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 128;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	localparam logic [DVD_W-1:0] MSE_CH_MAX  = DVD_W'(16646400);
	localparam logic [DVD_W-1:0] MSE_TOT_MAX = DVD_W'(49939200);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARK = 2'd1;

	// channel / division selector codes
	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE,
		SEL_TOTAL
	} sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAN,
		ST_ACC,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	// divider handshake toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/rgb_frame_difference_mse.sv =====
// Flow: an input word is taken in idle, its three channels then go in turn through the
// shared per-channel difference/square unit, the sums accumulate and the result word is
// emitted; a frame's last pixel adds four divisions (red, green, blue, total) before the
// emit. A new pixel is taken only after the last one's result has gone to the output.
// Reset: gain 1, mark mode off, sums and pixel count zero, no result pending.
`include "rgb_frame_difference_mse_macros.svh"

module rgb_frame_difference_mse
	import rfdm_pkg::*;
#(
	parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// first_red, first_green, first_blue, second_red, second_green, second_blue
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// diff_red, diff_green, diff_blue, mse_red, mse_green, mse_blue, mse_total, zero pad
	output logic [M_DATA_W-1:0]  m_tdata,
	// frame_done
	output logic                 m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_PIXELS);
	localparam int PAD_W = M_DATA_W - 3*PIX_W - 3*MSE_CH_W - MSE_TOT_W;

	state_t state_q, state_d;

	logic [PIX_W-1:0]    gain_q;
	logic                mark_q;
	logic [S_DATA_W-1:0] px_q;
	logic                last_q;
	sel_t                ch_q;
	sel_t                div_sel_q;

	logic [SUM_W-1:0]    sum_r_q, sum_g_q, sum_b_q;
	logic [CNT_W-1:0]    count_q;
	logic [15:0]         sq_q;
	sel_t                acc_ch_q;
	logic                acc_vld_q;

	logic [PIX_W-1:0]    diff_r_q, diff_g_q, diff_b_q;
	logic [MSE_CH_W-1:0] mse_r_q, mse_g_q, mse_b_q;
	logic [MSE_TOT_W-1:0] mse_t_q;

	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic                m_user_q;

	// sequencer outputs
	logic chan_en, acc_en, div_start, emit_ok, frame_clr;

	// shared channel unit
	logic [PIX_W-1:0]   a_c, b_c;
	logic signed [8:0]  d_c;
	logic signed [17:0] sq_full;
	logic signed [17:0] prod_c;
	logic signed [17:0] v_c;
	logic [PIX_W-1:0]   pix_c;

	// accumulator
	logic [SUM_W-1:0]   acc_old;
	logic [SUM_W:0]     acc_sum;
	logic [SUM_W-1:0]   acc_sat;

	// divider
	logic [TOT_W-1:0]   tot_c;
	logic [DVD_W-1:0]   dividend_c;
	logic [DVD_W-1:0]   quot;
	logic [DVD_W-1:0]   quot_cap;
	div_stat_t          div_stat;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_CHAN;
			ST_CHAN:      if (ch_q == SEL_BLUE) state_d = ST_ACC;
			ST_ACC:       state_d = last_q ? ST_DIV_START : ST_EMIT;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = (div_sel_q == SEL_TOTAL) ? ST_EMIT : ST_DIV_START;
				end
			end
			ST_EMIT:      if (!m_valid_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		s_tready  = 1'b0;
		chan_en   = 1'b0;
		acc_en    = 1'b0;
		div_start = 1'b0;
		emit_ok   = 1'b0;
		unique case (state_q)
			ST_IDLE:      s_tready  = 1'b1;
			ST_CHAN:      chan_en   = 1'b1;
			ST_ACC:       acc_en    = 1'b1;
			ST_DIV_START: div_start = 1'b1;
			ST_DIV_WAIT:  ;
			ST_EMIT:      emit_ok   = !m_valid_q || m_tready;
			default:      ;
		endcase
		frame_clr = emit_ok && last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= PIX_W'(1);
			mark_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_GAIN) begin
				gain_q <= cfg_data;
			end else if (cfg_index == REG_MARK) begin
				mark_q <= cfg_data[0];
			end
		end
	end

	// ---------------- input capture ----------------
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			px_q   <= s_tdata;
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= SEL_RED;
		end else if (s_tvalid && s_tready) begin
			ch_q <= SEL_RED;
		end else if (chan_en) begin
			ch_q <= sel_t'(ch_q + 2'd1);
		end
	end

	// ---------------- shared channel unit ----------------
	always_comb begin
		unique case (ch_q)
			SEL_RED:   begin a_c = px_q[7:0];   b_c = px_q[31:24]; end
			SEL_GREEN: begin a_c = px_q[15:8];  b_c = px_q[39:32]; end
			SEL_BLUE:  begin a_c = px_q[23:16]; b_c = px_q[47:40]; end
			default:   begin a_c = '0;          b_c = '0;          end
		endcase
	end

	assign d_c     = $signed({1'b0, a_c}) - $signed({1'b0, b_c});
	assign sq_full = d_c * d_c;
	assign prod_c  = d_c * $signed({1'b0, gain_q});
	assign v_c     = prod_c + 18'sd128;

	always_comb begin
		if (mark_q) begin
			pix_c = (d_c != 9'sd0) ? 8'd255 : 8'd0;
		end else if (v_c < 18'sd0) begin
			pix_c = 8'd0;
		end else if (v_c > 18'sd255) begin
			pix_c = 8'd255;
		end else begin
			pix_c = v_c[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (chan_en) begin
			sq_q     <= sq_full[15:0];
			acc_ch_q <= ch_q;
			unique case (ch_q)
				SEL_RED:   diff_r_q <= pix_c;
				SEL_GREEN: diff_g_q <= pix_c;
				SEL_BLUE:  diff_b_q <= pix_c;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= 1'b0;
		end else begin
			acc_vld_q <= chan_en;
		end
	end

	// ---------------- saturating accumulation ----------------
	always_comb begin
		unique case (acc_ch_q)
			SEL_RED:   acc_old = sum_r_q;
			SEL_GREEN: acc_old = sum_g_q;
			SEL_BLUE:  acc_old = sum_b_q;
			default:   acc_old = '0;
		endcase
	end

	assign acc_sum = {1'b0, acc_old} + {{(SUM_W-15){1'b0}}, sq_q};
	assign acc_sat = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			count_q <= '0;
		end else if (frame_clr) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			count_q <= '0;
		end else begin
			if (acc_vld_q) begin
				unique case (acc_ch_q)
					SEL_RED:   sum_r_q <= acc_sat;
					SEL_GREEN: sum_g_q <= acc_sat;
					SEL_BLUE:  sum_b_q <= acc_sat;
					default:   ;
				endcase
			end
			if (acc_en && (count_q < CNT_MAX)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// ---------------- division sequence ----------------
	assign tot_c = TOT_W'(sum_r_q) + TOT_W'(sum_g_q) + TOT_W'(sum_b_q);

	always_comb begin
		unique case (div_sel_q)
			SEL_RED:   dividend_c = {DVD_W'(sum_r_q)} << FRAC_W;
			SEL_GREEN: dividend_c = {DVD_W'(sum_g_q)} << FRAC_W;
			SEL_BLUE:  dividend_c = {DVD_W'(sum_b_q)} << FRAC_W;
			SEL_TOTAL: dividend_c = {DVD_W'(tot_c)} << FRAC_W;
			default:   dividend_c = '0;
		endcase
	end

	rfdm_div #(
		.DIVIDEND_W (DVD_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend_c),
		.divisor  (count_q),
		.stat     (div_stat),
		.quotient (quot)
	);

	always_comb begin
		if (div_sel_q == SEL_TOTAL) begin
			quot_cap = (quot > MSE_TOT_MAX) ? MSE_TOT_MAX : quot;
		end else begin
			quot_cap = (quot > MSE_CH_MAX) ? MSE_CH_MAX : quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_sel_q <= SEL_RED;
		end else if (acc_en) begin
			div_sel_q <= SEL_RED;
		end else if ((state_q == ST_DIV_WAIT) && div_stat.done) begin
			div_sel_q <= sel_t'(div_sel_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV_WAIT) && div_stat.done) begin
			unique case (div_sel_q)
				SEL_RED:   mse_r_q <= quot_cap[MSE_CH_W-1:0];
				SEL_GREEN: mse_g_q <= quot_cap[MSE_CH_W-1:0];
				SEL_BLUE:  mse_b_q <= quot_cap[MSE_CH_W-1:0];
				SEL_TOTAL: mse_t_q <= quot_cap[MSE_TOT_W-1:0];
				default:   ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_ok) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ok) begin
			m_user_q <= last_q;
			if (last_q) begin
				m_data_q <= {{PAD_W{1'b0}}, mse_t_q, mse_b_q, mse_g_q, mse_r_q,
				             diff_b_q, diff_g_q, diff_r_q};
			end else begin
				m_data_q <= {{(M_DATA_W-3*PIX_W){1'b0}}, diff_b_q, diff_g_q, diff_r_q};
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	`RFDM_ASSERT_NEXT(a_accept_starts_red, s_tvalid && s_tready,
		(state_q == ST_CHAN) && (ch_q == SEL_RED))
	`RFDM_ASSERT_NOW(a_done_only_waiting, div_stat.done, state_q == ST_DIV_WAIT)
	`RFDM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_MAX)
	`RFDM_ASSERT_NOW(a_plain_word_no_mse, m_tvalid && !m_tuser,
		m_tdata[M_DATA_W-1:3*PIX_W] == '0)

endmodule

// ===== src/rfdm_div.sv =====
`include "rgb_frame_difference_mse_macros.svh"

module rfdm_div
	import rfdm_pkg::*;
#(
	parameter int DIVIDEND_W = DVD_W,
	parameter int DIVISOR_W  = DVS_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output div_stat_t             stat,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dq_q[DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;

	`RFDM_ASSERT_NOW(a_div_no_restart, busy_q, !start)
	`RFDM_ASSERT_NEXT(a_div_start_busy, start, busy_q && (step_q == '0))
	`RFDM_ASSERT_NOW(a_div_step_range, busy_q, step_q <= LAST_STEP)

endmodule
